FILE: src/pol_pkg.sv
// Shared types, constants and helper functions for the partition owner lookup.
package pol_pkg;

  localparam int NDIM           = 3;
  localparam int MAX_PARTS      = 64;
  localparam int COORD_BITS     = 31;
  localparam int TABLE_DEPTH    = MAX_PARTS + 1;
  localparam int OWNER_BITS     = 7;
  localparam int DIM_BITS       = 2;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [COORD_BITS-1:0]     coord_t;
  typedef logic [OWNER_BITS-1:0]     owner_t;
  typedef logic [DIM_BITS-1:0]       dim_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  localparam cfg_index_t CFG_PART_COUNT_X = 2'd0;
  localparam cfg_index_t CFG_PART_COUNT_Y = 2'd1;
  localparam cfg_index_t CFG_PART_COUNT_Z = 2'd2;

  localparam dim_t DIM_X = 2'd0;
  localparam dim_t DIM_Y = 2'd1;
  localparam dim_t DIM_Z = 2'd2;

  typedef enum logic [2:0] {
    P_IDLE,
    P_BASE,
    P_LAST,
    P_SRCH,
    P_DONE
  } lane_phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } ctl_state_t;

  typedef struct packed {
    logic   done;
    owner_t owner;
    coord_t offset;
    logic   beyond;
  } lane_res_t;

  function automatic owner_t clamp_count(input owner_t v);
    owner_t r;
    if (v == '0) begin
      r = owner_t'(1);
    end else if (v > owner_t'(MAX_PARTS)) begin
      r = owner_t'(MAX_PARTS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic owner_t mid_point(input owner_t lo, input owner_t up);
    logic [OWNER_BITS:0] s;
    s = {1'b0, lo} + {1'b0, up};
    return s[OWNER_BITS:1];
  endfunction

  // True while the search interval still holds more than one candidate.
  function automatic logic span_open(input owner_t lo, input owner_t up);
    logic [OWNER_BITS:0] lo_inc;
    lo_inc = {1'b0, lo} + {{OWNER_BITS{1'b0}}, 1'b1};
    return lo_inc < {1'b0, up};
  endfunction

endpackage

FILE: src/pol_in_if.sv
// Input channel: boundary writes and coordinate lookups.
interface pol_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  pol_pkg::dim_t     dim_select;
  pol_pkg::owner_t   entry_index;
  pol_pkg::coord_t   boundary_value;
  pol_pkg::coord_t   coord_x;
  pol_pkg::coord_t   coord_y;
  pol_pkg::coord_t   coord_z;

  modport source (
    output valid, operation, dim_select, entry_index, boundary_value,
           coord_x, coord_y, coord_z,
    input  ready
  );
  modport sink (
    input  valid, operation, dim_select, entry_index, boundary_value,
           coord_x, coord_y, coord_z,
    output ready
  );
endinterface

FILE: src/pol_out_if.sv
// Result channel: owning partitions and offsets of one lookup.
interface pol_out_if;
  logic              valid;
  logic              ready;
  pol_pkg::owner_t   owner_x;
  pol_pkg::owner_t   owner_y;
  pol_pkg::owner_t   owner_z;
  pol_pkg::coord_t   offset_x;
  pol_pkg::coord_t   offset_y;
  pol_pkg::coord_t   offset_z;
  logic              out_of_range;

  modport source (
    output valid, owner_x, owner_y, owner_z, offset_x, offset_y, offset_z,
           out_of_range,
    input  ready
  );
  modport sink (
    input  valid, owner_x, owner_y, owner_z, offset_x, offset_y, offset_z,
           out_of_range,
    output ready
  );
endinterface

FILE: src/pol_cfg_if.sv
// Configuration write channel: register index and write data.
interface pol_cfg_if;
  logic                  valid;
  logic                  ready;
  pol_pkg::cfg_index_t   index;
  pol_pkg::owner_t       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/pol_ram.sv
// Generic simple dual-port RAM with registered read data.
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/pol_lane.sv
// One dimension: boundary table bank and its binary-search sequencer.
module pol_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pol_pkg::coord_t    coord,
  input  pol_pkg::owner_t    count,
  input  logic               wr_en,
  input  pol_pkg::owner_t    wr_addr,
  input  pol_pkg::coord_t    wr_data,
  output pol_pkg::lane_res_t res
);

  pol_pkg::lane_phase_t phase_r, phase_nxt;
  pol_pkg::owner_t      lo_r, lo_nxt;
  pol_pkg::owner_t      up_r, up_nxt;
  pol_pkg::owner_t      mi_r, mi_nxt;
  pol_pkg::coord_t      coord_r, coord_nxt;
  pol_pkg::coord_t      lo_val_r, lo_val_nxt;
  logic                 beyond_r, beyond_nxt;
  pol_pkg::owner_t      rd_addr;
  pol_pkg::coord_t      rd_data;

  pol_ram #(
    .WIDTH (pol_pkg::COORD_BITS),
    .DEPTH (pol_pkg::TABLE_DEPTH)
  ) u_bank (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The next probe address follows straight from this cycle's compare.
  always_comb begin
    phase_nxt  = phase_r;
    lo_nxt     = lo_r;
    up_nxt     = up_r;
    coord_nxt  = coord_r;
    lo_val_nxt = lo_val_r;
    beyond_nxt = beyond_r;
    rd_addr    = mi_r;
    unique case (phase_r)
      pol_pkg::P_IDLE, pol_pkg::P_DONE: begin
        if (start) begin
          phase_nxt = pol_pkg::P_BASE;
          lo_nxt    = '0;
          up_nxt    = count + pol_pkg::owner_t'(1);
          coord_nxt = coord;
          rd_addr   = '0;
        end
      end
      pol_pkg::P_BASE: begin
        lo_val_nxt = rd_data;
        rd_addr    = count;
        phase_nxt  = pol_pkg::P_LAST;
      end
      pol_pkg::P_LAST: begin
        beyond_nxt = coord_r > rd_data;
        rd_addr    = pol_pkg::mid_point(lo_r, up_r);
        phase_nxt  = pol_pkg::P_SRCH;
      end
      pol_pkg::P_SRCH: begin
        if (coord_r >= rd_data) begin
          lo_nxt     = mi_r;
          lo_val_nxt = rd_data;
        end else begin
          up_nxt = mi_r;
        end
        if (pol_pkg::span_open(lo_nxt, up_nxt)) begin
          rd_addr = pol_pkg::mid_point(lo_nxt, up_nxt);
        end else begin
          phase_nxt = pol_pkg::P_DONE;
        end
      end
      default: begin
        phase_nxt = pol_pkg::P_IDLE;
      end
    endcase
  end

  assign mi_nxt = rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pol_pkg::P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    up_r     <= up_nxt;
    mi_r     <= mi_nxt;
    coord_r  <= coord_nxt;
    lo_val_r <= lo_val_nxt;
    beyond_r <= beyond_nxt;
  end

  always_comb begin
    res.done   = (phase_r == pol_pkg::P_DONE);
    res.owner  = lo_r;
    res.offset = coord_r - lo_val_r;
    res.beyond = beyond_r;
  end

endmodule

FILE: src/partition_owner_lookup.sv
// Top level: configuration registers, item control, three search lanes and the result register.
// Finds the partition that owns a coordinate in each of three dimensions, and the offset
// inside it, by binary search over per-dimension tables of ascending partition starts.
// A boundary write is taken while the block is idle and gives no result. A lookup occupies
// the block until all three lanes finish, and longer while the result register still holds
// an untaken word: each lane reads its first and last boundary, then makes one probe per
// cycle through its single-read-port table bank, the next address following from the
// current compare. The three lanes search side by side. A finished result waits in the
// output register while the next item is taken. Part counts outside 1..64 are clamped;
// tables are undefined until written, and no clearing pass runs after reset.
module partition_owner_lookup (
  input  logic        clk,
  input  logic        rst_n,
  pol_in_if.sink      in_ch,
  pol_out_if.source   out_ch,
  pol_cfg_if.sink     cfg_ch
);

  pol_pkg::ctl_state_t state_r, state_nxt;
  pol_pkg::owner_t     part_count_r [pol_pkg::NDIM];
  pol_pkg::owner_t     count_clamped [pol_pkg::NDIM];
  pol_pkg::coord_t     coords [pol_pkg::NDIM];
  pol_pkg::lane_res_t  lane_res [pol_pkg::NDIM];
  logic [pol_pkg::NDIM-1:0] lane_wr_en;
  logic [pol_pkg::NDIM-1:0] lane_done;
  logic                in_acc;
  logic                lookup_acc;
  logic                write_ok;
  logic                all_done;
  logic                out_free;
  logic                out_load;
  logic                out_valid_r, out_valid_nxt;
  pol_pkg::owner_t     owner_r [pol_pkg::NDIM];
  pol_pkg::coord_t     offset_r [pol_pkg::NDIM];
  logic                oor_r;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < pol_pkg::NDIM; d++) begin
        part_count_r[d] <= pol_pkg::owner_t'(1);
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pol_pkg::CFG_PART_COUNT_X: part_count_r[0] <= cfg_ch.data;
        pol_pkg::CFG_PART_COUNT_Y: part_count_r[1] <= cfg_ch.data;
        pol_pkg::CFG_PART_COUNT_Z: part_count_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < pol_pkg::NDIM; d++) begin
      count_clamped[d] = pol_pkg::clamp_count(part_count_r[d]);
    end
  end

  // Item acceptance and write decode
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign lookup_acc = in_acc && (in_ch.operation == pol_pkg::OP_LOOKUP);
  assign write_ok   = in_acc && (in_ch.operation == pol_pkg::OP_WRITE)
                      && (in_ch.entry_index <= pol_pkg::owner_t'(pol_pkg::MAX_PARTS));

  assign lane_wr_en[0] = write_ok && (in_ch.dim_select == pol_pkg::DIM_X);
  assign lane_wr_en[1] = write_ok && (in_ch.dim_select == pol_pkg::DIM_Y);
  assign lane_wr_en[2] = write_ok && (in_ch.dim_select == pol_pkg::DIM_Z);

  assign coords[0] = in_ch.coord_x;
  assign coords[1] = in_ch.coord_y;
  assign coords[2] = in_ch.coord_z;

  for (genvar g = 0; g < pol_pkg::NDIM; g++) begin : g_lane
    pol_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (lookup_acc),
      .coord   (coords[g]),
      .count   (count_clamped[g]),
      .wr_en   (lane_wr_en[g]),
      .wr_addr (in_ch.entry_index),
      .wr_data (in_ch.boundary_value),
      .res     (lane_res[g])
    );
    assign lane_done[g] = lane_res[g].done;
  end

  assign all_done = &lane_done;
  assign out_free = !out_valid_r || out_ch.ready;

  // Control state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pol_pkg::ST_IDLE: begin
        if (lookup_acc) begin
          state_nxt = pol_pkg::ST_BUSY;
        end
      end
      pol_pkg::ST_BUSY: begin
        if (all_done && out_free) begin
          state_nxt = pol_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pol_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      pol_pkg::ST_IDLE: in_ch.ready = 1'b1;
      pol_pkg::ST_BUSY: out_load    = all_done && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result register: hold until taken
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int d = 0; d < pol_pkg::NDIM; d++) begin
        owner_r[d]  <= lane_res[d].owner;
        offset_r[d] <= lane_res[d].offset;
      end
      oor_r <= lane_res[0].beyond || lane_res[1].beyond || lane_res[2].beyond;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.owner_x      = owner_r[0];
  assign out_ch.owner_y      = owner_r[1];
  assign out_ch.owner_z      = owner_r[2];
  assign out_ch.offset_x     = offset_r[0];
  assign out_ch.offset_y     = offset_r[1];
  assign out_ch.offset_z     = offset_r[2];
  assign out_ch.out_of_range = oor_r;

  // Checks
  a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_acc |=> !in_ch.ready)
    else $error("input taken again right after a lookup");

  a_load_needs_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> all_done && (state_r == pol_pkg::ST_BUSY))
    else $error("result loaded before all lanes finished");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.operation == pol_pkg::OP_WRITE)) |=> !$rose(out_ch.valid))
    else $error("boundary write produced a result");

  a_owner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (lane_res[0].owner <= count_clamped[0])
              && (lane_res[1].owner <= count_clamped[1])
              && (lane_res[2].owner <= count_clamped[2]))
    else $error("owner beyond part count");

endmodule
